/* rtl/core/lpc_pkg.sv */
`default_nettype none

package lpc_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam int KEY_W  = 24;
    localparam int USES_W = 32;
    localparam int COST_W = 31;
    localparam int SLOT_W = 3;

    localparam logic [USES_W-1:0] USES_MAX = '1;

    localparam logic MODE_RECORD = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [USES_W-1:0] uses;
        logic [COST_W-1:0] cost;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/lfu_price_cache.sv */
// one word at a time: after input accept o_stall stays high until its result is committed
// the scan covers all n occupied entries, with n the fill count; an empty cache scans none
// the scan does one memory read per occupied entry, then a compare
// a waiting result sits in the output register while the next word is scanned
// reset (synchronous, active low) clears the fill count and control state;
// entry contents are not cleared, the fill count marks which entries are live
`default_nettype none

module lfu_price_cache #(
    parameter int ENTRIES = lpc_pkg::ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_mode,
    input  wire logic [lpc_pkg::KEY_W-1:0]   i_item_id,
    input  wire logic [lpc_pkg::COST_W-1:0]  i_new_price,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_hit,
    output logic [lpc_pkg::SLOT_W-1:0]       o_slot,
    output logic                             o_evicted,
    output logic [lpc_pkg::COST_W-1:0]       o_price
);
    import lpc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    lpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    lpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_item_id   (i_item_id),
        .i_new_price (i_new_price),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_evicted   (o_evicted),
        .o_price     (o_price)
    );

    // a word in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a word was still in flight");

    // a commit never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !(o_valid && i_stall))
        else $error("commit overwrote a stalled result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("commit did not raise o_valid");

    a_start_commit_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.start && (w_cmd.commit || w_cmd.scan)))
        else $error("start overlaps scan or commit");

endmodule

`default_nettype wire

/* rtl/core/lpc_ctrl.sv */
`default_nettype none

module lpc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  lpc_pkg::t_status     i_status,
    output logic                 o_stall,
    output lpc_pkg::t_cmd        o_cmd
);
    import lpc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        o_stall      = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                // hold the finished word until the output register frees up
                if (i_status.scan_done && i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lpc_dp.sv */
`default_nettype none

module lpc_dp #(
    parameter int ENTRIES = lpc_pkg::ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_mode,
    input  wire logic [lpc_pkg::KEY_W-1:0]   i_item_id,
    input  wire logic [lpc_pkg::COST_W-1:0]  i_new_price,
    input  lpc_pkg::t_cmd                    i_cmd,
    output lpc_pkg::t_status                 o_status,
    input  wire logic                        i_out_stall,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic [lpc_pkg::SLOT_W-1:0]       o_slot,
    output logic                             o_evicted,
    output logic [lpc_pkg::COST_W-1:0]       o_price
);
    import lpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    t_entry r_mem [ENTRIES];

    // latched request
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [COST_W-1:0] r_new_price;

    // fill count, doubles as the scan limit
    logic [CNT_W-1:0]  r_used;

    // scan pipeline
    logic [CNT_W-1:0]  r_rd_cnt;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    t_entry            r_rd_word;

    logic              r_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [USES_W-1:0] r_hit_uses;
    logic [COST_W-1:0] r_hit_cost;
    logic [IDX_W-1:0]  r_min_idx;
    logic [USES_W-1:0] r_min_uses;

    // output register
    logic              r_out_vld;
    logic              r_out_hit;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_evicted;
    logic [COST_W-1:0] r_out_price;

    logic              w_issue;
    logic              w_full;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_idx;
    t_entry            w_wr_word;
    logic              w_grow;
    logic              w_res_hit;
    logic [IDX_W-1:0]  w_res_idx;
    logic [7:0]        w_res_idx8;
    logic              w_res_evicted;
    logic [COST_W-1:0] w_res_price;

    assign w_issue = i_cmd.scan && (r_rd_cnt != r_used);
    assign w_full  = (r_used == CNT_W'(ENTRIES));

    assign o_status = '{
        scan_done: (r_rd_cnt == r_used) && !r_cmp_vld,
        out_free:  !r_out_vld || !i_out_stall
    };

    always_comb begin
        w_wr_en        = 1'b0;
        w_wr_idx       = r_hit_idx;
        w_wr_word.key  = r_key;
        w_wr_word.uses = USES_W'(1);
        w_wr_word.cost = r_new_price;
        w_grow         = 1'b0;
        w_res_hit      = 1'b0;
        w_res_idx      = '0;
        w_res_evicted  = 1'b0;
        w_res_price    = '0;
        if (r_found) begin
            w_res_hit   = 1'b1;
            w_res_idx   = r_hit_idx;
            w_res_price = r_hit_cost;
            if (r_mode == MODE_RECORD && r_hit_uses != USES_MAX) begin
                w_wr_en        = 1'b1;
                w_wr_word.uses = r_hit_uses + USES_W'(1);
                w_wr_word.cost = r_hit_cost;
            end
        end else if (r_mode == MODE_RECORD) begin
            w_wr_en     = 1'b1;
            w_res_price = r_new_price;
            if (w_full) begin
                w_wr_idx      = r_min_idx;
                w_res_evicted = 1'b1;
            end else begin
                w_wr_idx = r_used[IDX_W-1:0];
                w_grow   = 1'b1;
            end
            w_res_idx = w_wr_idx;
        end
    end

    assign w_res_idx8 = 8'(w_res_idx);

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_word;
        end
        if (w_issue) begin
            r_rd_word <= r_mem[r_rd_cnt[IDX_W-1:0]];
            r_cmp_idx <= r_rd_cnt[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode      <= i_mode;
            r_key       <= i_item_id;
            r_new_price <= i_new_price;
        end
        if (r_cmp_vld) begin
            if (!r_found && r_rd_word.key == r_key) begin
                r_hit_idx  <= r_cmp_idx;
                r_hit_uses <= r_rd_word.uses;
                r_hit_cost <= r_rd_word.cost;
            end
            // strict compare keeps the lowest index on ties
            if (r_cmp_idx == '0 || r_rd_word.uses < r_min_uses) begin
                r_min_idx  <= r_cmp_idx;
                r_min_uses <= r_rd_word.uses;
            end
        end
        if (i_cmd.commit) begin
            r_out_hit     <= w_res_hit;
            r_out_slot    <= w_res_idx8[SLOT_W-1:0];
            r_out_evicted <= w_res_evicted;
            r_out_price   <= w_res_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= w_issue;
            if (i_cmd.start) begin
                r_rd_cnt <= '0;
                r_found  <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
                if (r_cmp_vld && r_rd_word.key == r_key) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit && w_grow) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_vld;
    assign o_hit     = r_out_hit;
    assign o_slot    = r_out_slot;
    assign o_evicted = r_out_evicted;
    assign o_price   = r_out_price;

endmodule

`default_nettype wire
